// ----- sv/http_body_deframer_top_macros.svh -----
// ----------------------------------------------------------------------------
// http_body_deframer_top_macros: assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_BODY_DEFRAMER_TOP_MACROS_SVH
`define HTTP_BODY_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define HBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hbd assertion failed");
// pre in one cycle implies post in the next
`define HBD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("hbd assertion failed");
`else
`define HBD_ASSERT(lbl, prop)
`define HBD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- sv/hbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hbd_pkg: shared definitions for the HTTP body deframer
// Sizing constants, command and status codes, and the result record.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int unsigned LINE_LIMIT = 128;
  localparam int unsigned COUNT_BITS = 32;
  // remaining-byte counter must also hold a full 32-bit content length
  localparam int unsigned LEFT_BITS  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam int unsigned LC_BITS    = $clog2(LINE_LIMIT + 1);

  localparam logic [1:0] CMD_DATA      = 2'd0;
  localparam logic [1:0] CMD_CONN_END  = 2'd1;
  localparam logic [1:0] CMD_CANCEL    = 2'd2;
  localparam logic [1:0] CMD_READ_FAIL = 2'd3;

  localparam logic [1:0] MODE_LENGTH  = 2'd0;
  localparam logic [1:0] MODE_CHUNKED = 2'd1;
  localparam logic [1:0] MODE_CLOSE   = 2'd2;

  localparam logic [2:0] ST_COMPLETE  = 3'd0;
  localparam logic [2:0] ST_PREMATURE = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_READ_FAIL = 3'd4;

  localparam logic [0:0] CFG_FRAMING_MODE = 1'b0;
  localparam logic [0:0] CFG_BODY_LENGTH  = 1'b1;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  out_byte;
    logic [2:0]  final_status;
    logic [31:0] delivered_count;
    logic        last;
  } result_t;

  // delivered count as reported: low 32 bits, zero extended if narrower
  function automatic logic [31:0] cnt_to_out(input logic [COUNT_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[31:0];
  endfunction

endpackage

// ----- sv/hbd_core.sv -----
// ----------------------------------------------------------------------------
// hbd_core: framing state and per-item decode
// Works out the results of one item and the next framing state in one pass;
// the state advances when the item is consumed.
// ----------------------------------------------------------------------------
module hbd_core import hbd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    framing_mode_i,
  input  logic [31:0]   body_length_i,
  input  logic [1:0]    cmd_i,
  input  logic [7:0]    byte_i,
  input  logic          consume_i,
  output logic [1:0]    res_n_o,
  output result_t       res0_o,
  output result_t       res1_o
);

  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_CONTENT  = 3'd1;
  localparam logic [2:0] PH_SIZE     = 3'd2;
  localparam logic [2:0] PH_SIZE_BAD = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_CRLF     = 3'd5;
  localparam logic [2:0] PH_TRAILER  = 3'd6;
  localparam logic [2:0] PH_CLOSE    = 3'd7;

  logic [2:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] size_q, size_d;
  logic [LEFT_BITS-1:0]  left_q, left_d;
  logic [COUNT_BITS-1:0] deliv_q, deliv_d;
  logic [LC_BITS-1:0]    lcnt_q, lcnt_d;
  logic                  prev_cr_q, prev_cr_d;
  logic                  in_ext_q, in_ext_d;
  logic                  digit_q, digit_d;
  logic                  crlf_q, crlf_d;

  logic [2:0]            eff_phase;
  logic [LEFT_BITS-1:0]  eff_left, left_dec;
  logic [COUNT_BITS-1:0] deliv_inc;
  logic [COUNT_BITS:0]   chunk_sum;
  logic [LC_BITS-1:0]    lcnt_inc;
  logic                  deliv_full, chunk_ovf, size_ovf;
  logic                  is_cr, is_lf, is_semi;
  logic [4:0]            hex;
  logic                  early, emit_data, emit_stat;
  logic [2:0]            stat_code;
  result_t               data_r, stat_r;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  assign is_cr      = (byte_i == CH_CR);
  assign is_lf      = (byte_i == CH_LF);
  assign is_semi    = (byte_i == CH_SEMI);
  assign hex        = hex_decode(byte_i);
  assign deliv_inc  = deliv_q + 1'b1;
  assign deliv_full = &deliv_q;
  assign chunk_sum  = {1'b0, size_q} + {1'b0, deliv_q};
  assign chunk_ovf  = chunk_sum[COUNT_BITS];
  // shifting in another digit overflows iff the top nibble is already used
  assign size_ovf   = (size_q[COUNT_BITS-1 -: 4] != 4'd0);
  assign lcnt_inc   = lcnt_q + 1'b1;
  assign left_dec   = eff_left - 1'b1;

  always_comb begin
    phase_d   = phase_q;
    size_d    = size_q;
    deliv_d   = deliv_q;
    lcnt_d    = lcnt_q;
    prev_cr_d = prev_cr_q;
    in_ext_d  = in_ext_q;
    digit_d   = digit_q;
    crlf_d    = crlf_q;
    early     = 1'b0;
    emit_data = 1'b0;
    emit_stat = 1'b0;
    stat_code = ST_COMPLETE;
    eff_phase = phase_q;
    eff_left  = left_q;

    // first item of a body samples the framing registers
    if (phase_q == PH_START) begin
      eff_left = LEFT_BITS'(body_length_i);
      if (cmd_i == CMD_CANCEL) begin
        early     = 1'b1;
        emit_stat = 1'b1;
        stat_code = ST_CANCELLED;
      end else begin
        unique case (framing_mode_i)
          MODE_LENGTH: begin
            if (body_length_i == 32'd0) begin
              early     = 1'b1;
              emit_stat = 1'b1;
              stat_code = ST_COMPLETE;
            end else begin
              eff_phase = PH_CONTENT;
            end
          end
          MODE_CHUNKED: eff_phase = PH_SIZE;
          MODE_CLOSE:   eff_phase = PH_CLOSE;
          default: begin
            early     = 1'b1;
            emit_stat = 1'b1;
            stat_code = ST_MALFORMED;
          end
        endcase
      end
    end

    phase_d = eff_phase;
    left_d  = eff_left;

    if (!early) begin
      unique case (cmd_i)
        CMD_CANCEL: begin
          emit_stat = 1'b1;
          stat_code = ST_CANCELLED;
        end
        CMD_READ_FAIL: begin
          emit_stat = 1'b1;
          stat_code = ST_READ_FAIL;
        end
        CMD_CONN_END: begin
          emit_stat = 1'b1;
          stat_code = (eff_phase == PH_CLOSE) ? ST_COMPLETE : ST_PREMATURE;
        end
        default: begin
          case (eff_phase)
            PH_CONTENT, PH_DATA, PH_CLOSE: begin
              if (deliv_full) begin
                emit_stat = 1'b1;
                stat_code = ST_MALFORMED;
              end else begin
                emit_data = 1'b1;
                deliv_d   = deliv_inc;
                if (eff_phase != PH_CLOSE) begin
                  left_d = left_dec;
                  if (left_dec == '0) begin
                    if (eff_phase == PH_CONTENT) begin
                      emit_stat = 1'b1;
                      stat_code = ST_COMPLETE;
                    end else begin
                      phase_d   = PH_CRLF;
                      crlf_d    = 1'b0;
                      prev_cr_d = 1'b0;
                    end
                  end
                end
              end
            end
            PH_SIZE, PH_SIZE_BAD, PH_TRAILER: begin
              if (is_lf) begin
                if (lcnt_q == '0 || !prev_cr_q) begin
                  emit_stat = 1'b1;
                  stat_code = ST_MALFORMED;
                end else if (eff_phase == PH_TRAILER) begin
                  if (lcnt_q == LC_BITS'(1)) begin
                    emit_stat = 1'b1;
                    stat_code = ST_COMPLETE;
                  end else begin
                    phase_d   = PH_TRAILER;
                    size_d    = '0;
                    lcnt_d    = '0;
                    prev_cr_d = 1'b0;
                    in_ext_d  = 1'b0;
                    digit_d   = 1'b0;
                  end
                end else if (eff_phase == PH_SIZE_BAD || !digit_q || chunk_ovf) begin
                  emit_stat = 1'b1;
                  stat_code = ST_MALFORMED;
                end else if (size_q == '0) begin
                  // last chunk: trailer section follows
                  phase_d   = PH_TRAILER;
                  size_d    = '0;
                  lcnt_d    = '0;
                  prev_cr_d = 1'b0;
                  in_ext_d  = 1'b0;
                  digit_d   = 1'b0;
                end else begin
                  left_d  = LEFT_BITS'(size_q);
                  phase_d = PH_DATA;
                end
              end else begin
                if (eff_phase == PH_SIZE && !in_ext_q) begin
                  if (prev_cr_q) begin
                    phase_d = PH_SIZE_BAD;
                  end else if (is_semi) begin
                    in_ext_d = 1'b1;
                  end else if (!is_cr) begin
                    if (!hex[4] || size_ovf) begin
                      phase_d = PH_SIZE_BAD;
                    end else begin
                      size_d  = {size_q[COUNT_BITS-5:0], hex[3:0]};
                      digit_d = 1'b1;
                    end
                  end
                end
                prev_cr_d = is_cr;
                lcnt_d    = lcnt_inc;
                if (lcnt_inc >= LC_BITS'(LINE_LIMIT)) begin
                  emit_stat = 1'b1;
                  stat_code = ST_MALFORMED;
                end
              end
            end
            PH_CRLF: begin
              if (!crlf_q) begin
                prev_cr_d = is_cr;
                crlf_d    = 1'b1;
              end else if (!prev_cr_q || !is_lf) begin
                emit_stat = 1'b1;
                stat_code = ST_MALFORMED;
              end else begin
                crlf_d    = 1'b0;
                phase_d   = PH_SIZE;
                size_d    = '0;
                lcnt_d    = '0;
                prev_cr_d = 1'b0;
                in_ext_d  = 1'b0;
                digit_d   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      endcase
    end

    data_r = '{is_status: 1'b0, out_byte: byte_i, final_status: ST_COMPLETE,
               delivered_count: 32'd0, last: !emit_stat};
    stat_r = '{is_status: 1'b1, out_byte: 8'd0, final_status: stat_code,
               delivered_count: cnt_to_out(deliv_d), last: 1'b1};

    // a status closes the body: back to the start state
    if (emit_stat) begin
      phase_d   = PH_START;
      size_d    = '0;
      left_d    = '0;
      deliv_d   = '0;
      lcnt_d    = '0;
      prev_cr_d = 1'b0;
      in_ext_d  = 1'b0;
      digit_d   = 1'b0;
      crlf_d    = 1'b0;
    end
  end

  assign res_n_o = {1'b0, emit_data} + {1'b0, emit_stat};
  assign res0_o  = emit_data ? data_r : stat_r;
  assign res1_o  = stat_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      size_q    <= '0;
      left_q    <= '0;
      deliv_q   <= '0;
      lcnt_q    <= '0;
      prev_cr_q <= 1'b0;
      in_ext_q  <= 1'b0;
      digit_q   <= 1'b0;
      crlf_q    <= 1'b0;
    end else if (consume_i) begin
      phase_q   <= phase_d;
      size_q    <= size_d;
      left_q    <= left_d;
      deliv_q   <= deliv_d;
      lcnt_q    <= lcnt_d;
      prev_cr_q <= prev_cr_d;
      in_ext_q  <= in_ext_d;
      digit_q   <= digit_d;
      crlf_q    <= crlf_d;
    end
  end

endmodule

// ----- sv/hbd_outbuf.sv -----
// ----------------------------------------------------------------------------
// hbd_outbuf: two-slot result buffer
// Takes up to two results per cycle and hands them out one per handshake.
// ----------------------------------------------------------------------------
module hbd_outbuf import hbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  input  logic       ready_i,
  output logic       valid_o,
  output result_t    head_o,
  output logic [1:0] cnt_o
);

  result_t    slot0_q, slot0_d, slot1_q, slot1_d, shifted;
  logic [1:0] cnt_q, cnt_d, rem;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot0_q;
  assign cnt_o   = cnt_q;
  assign pop     = valid_o && ready_i;
  assign rem     = cnt_q - {1'b0, pop};
  assign shifted = pop ? slot1_q : slot0_q;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    unique case (rem)
      2'd0: begin
        slot0_d = res0_i;
        slot1_d = res1_i;
      end
      2'd1: begin
        slot0_d = shifted;
        slot1_d = res0_i;
      end
      default: ;  // full and not popping: nothing is pushed
    endcase
    cnt_d = rem + push_n_i;
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- sv/http_body_deframer_top.sv -----
// ----------------------------------------------------------------------------
// http_body_deframer_top: HTTP/1.1 response body deframer
// Content-length, chunked or until-close framing over a byte stream.
// ----------------------------------------------------------------------------
// One input item per clock while the output buffer has room: an item is
// registered, decoded in the following cycle and its results land in a
// two-slot output buffer, whose head is the result stream. Items that give
// at most one result stream at one per cycle while results are taken. An
// item that gives a body byte plus its final status needs both buffer slots,
// so it waits until the buffer has drained; this happens at the end of a
// body. Items that give no result (size and trailer line bytes, chunk CRLF)
// never wait for buffer space. Configuration is sampled on the first item of
// each body.
`include "http_body_deframer_top_macros.svh"

module http_body_deframer_top import hbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] out_byte, [10:8] final_status,
                                        // [42:11] delivered_count, [47:43] zero
  output logic [0:0]  m_axis_tuser_o,   // [0] is_status
  output logic        m_axis_tlast_o
);

  logic [1:0]  framing_mode_q;
  logic [31:0] body_length_q;
  logic        in_valid_q, in_valid_d;
  logic [1:0]  in_cmd_q;
  logic [7:0]  in_byte_q;
  logic        s_accept, consume;
  logic [1:0]  core_n, ob_cnt, ob_free;
  result_t     res0, res1, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      framing_mode_q <= MODE_LENGTH;
      body_length_q  <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAMING_MODE: framing_mode_q <= cfg_wdata_i[1:0];
        CFG_BODY_LENGTH:  body_length_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign ob_free         = 2'd2 - ob_cnt;
  assign consume         = in_valid_q && (core_n <= ob_free);
  assign s_axis_tready_o = !in_valid_q || consume;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = s_accept || (in_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  hbd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .framing_mode_i (framing_mode_q),
    .body_length_i  (body_length_q),
    .cmd_i          (in_cmd_q),
    .byte_i         (in_byte_q),
    .consume_i      (consume),
    .res_n_o        (core_n),
    .res0_o         (res0),
    .res1_o         (res1)
  );

  hbd_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (consume ? core_n : 2'd0),
    .res0_i   (res0),
    .res1_i   (res1),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .head_o   (head),
    .cnt_o    (ob_cnt)
  );

  assign m_axis_tdata_o = {5'd0, head.delivered_count, head.final_status, head.out_byte};
  assign m_axis_tuser_o = head.is_status;
  assign m_axis_tlast_o = head.last;

  `HBD_ASSERT(a_outbuf_bound, ob_cnt <= 2'd2)
  `HBD_ASSERT(a_status_is_last, !(m_axis_tvalid_o && m_axis_tuser_o[0]) || m_axis_tlast_o)
  `HBD_ASSERT(a_data_clean, !(m_axis_tvalid_o && !m_axis_tuser_o[0]) || (m_axis_tdata_o[47:8] == 40'd0))
  `HBD_ASSERT_NEXT(a_accept_loads, s_axis_tvalid_i && s_axis_tready_o, in_valid_q)

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: HTTP body deframer
// Sends byte and event items through the deframer in all framing modes, with
// random pauses on both streams. Every item is predicted as it is accepted.
// Body bytes and final statuses are checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import hbd_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);
  localparam int ITEM_TARGET   = 1450;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    BODY_IDLE, LEN_BODY, SIZE_LINE, SIZE_LINE_BAD,
    CHUNK_DATA, CHUNK_END, TRAILER_LINE, CLOSE_BODY
  } body_phase_e;

  typedef enum logic [1:0] {LINE_MORE, LINE_BAD, LINE_DONE} line_verdict_e;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
  } stream_item_t;

  // tracks the deframer state and the results still owed by the block
  class deframer_tracker;
    logic [1:0]      mode;
    logic [31:0]     length;
    body_phase_e     ph;
    longint unsigned size_acc;
    longint unsigned left;
    longint unsigned count;
    int unsigned     line_len;
    bit              saw_cr;
    bit              in_ext;
    bit              got_digit;
    bit              crlf_second;
    result_t         fresh[$];
    result_t         pending_results[$];
    int              errors;

    function new();
      mode   = MODE_LENGTH;
      length = '0;
      errors = 0;
      reset_body();
    endfunction

    function void reset_body();
      ph          = BODY_IDLE;
      size_acc    = 0;
      left        = 0;
      count       = 0;
      line_len    = 0;
      saw_cr      = 1'b0;
      in_ext      = 1'b0;
      got_digit   = 1'b0;
      crlf_second = 1'b0;
    endfunction

    function void begin_line(body_phase_e next);
      ph        = next;
      size_acc  = 0;
      line_len  = 0;
      saw_cr    = 1'b0;
      in_ext    = 1'b0;
      got_digit = 1'b0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == CFG_FRAMING_MODE) mode = val[1:0];
      else length = val;
    endfunction

    function bit at_body_start();
      return ph == BODY_IDLE;
    endfunction

    function void emit_status(logic [2:0] st);
      result_t r;
      r                 = '0;
      r.is_status       = 1'b1;
      r.final_status    = st;
      r.delivered_count = count[31:0];
      fresh.push_back(r);
      reset_body();
    endfunction

    // false when one more byte would overflow the delivered count
    function bit emit_byte(logic [7:0] b);
      result_t r;
      if (count >= COUNT_MAX) return 1'b0;
      r          = '0;
      r.out_byte = b;
      fresh.push_back(r);
      count++;
      return 1'b1;
    endfunction

    function int hex_digit(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      return -1;
    endfunction

    // one byte of a size or trailer line
    function line_verdict_e line_step(logic [7:0] b);
      int d;
      if (b == CH_LF) return (line_len == 0 || !saw_cr) ? LINE_BAD : LINE_DONE;
      if (ph == SIZE_LINE && !in_ext) begin
        d = hex_digit(b);
        if (saw_cr) begin
          ph = SIZE_LINE_BAD;
        end else if (b != CH_CR) begin
          if (b == CH_SEMI) begin
            in_ext = 1'b1;
          end else if (d < 0 || size_acc > (COUNT_MAX - 64'(d)) / 16) begin
            ph = SIZE_LINE_BAD;
          end else begin
            size_acc  = size_acc * 16 + 64'(d);
            got_digit = 1'b1;
          end
        end
      end
      saw_cr = (b == CH_CR);
      line_len++;
      return (line_len >= LINE_LIMIT) ? LINE_BAD : LINE_MORE;
    endfunction

    function void decode_item(logic [1:0] cmd, logic [7:0] b);
      line_verdict_e v;
      if (ph == BODY_IDLE) begin
        if (cmd == CMD_CANCEL) begin
          emit_status(ST_CANCELLED);
          return;
        end
        case (mode)
          MODE_LENGTH: begin
            if (length == 0) begin
              emit_status(ST_COMPLETE);
              return;
            end
            left = length;
            ph   = LEN_BODY;
          end
          MODE_CHUNKED: begin_line(SIZE_LINE);
          MODE_CLOSE:   ph = CLOSE_BODY;
          default: begin
            emit_status(ST_MALFORMED);
            return;
          end
        endcase
      end

      case (cmd)
        CMD_CANCEL:    emit_status(ST_CANCELLED);
        CMD_READ_FAIL: emit_status(ST_READ_FAIL);
        CMD_CONN_END:  emit_status(ph == CLOSE_BODY ? ST_COMPLETE : ST_PREMATURE);
        default: begin
          case (ph)
            LEN_BODY: begin
              if (!emit_byte(b)) begin
                emit_status(ST_MALFORMED);
              end else begin
                left--;
                if (left == 0) emit_status(ST_COMPLETE);
              end
            end
            CLOSE_BODY: begin
              if (!emit_byte(b)) emit_status(ST_MALFORMED);
            end
            SIZE_LINE, SIZE_LINE_BAD: begin
              v = line_step(b);
              if (v == LINE_BAD) begin
                emit_status(ST_MALFORMED);
              end else if (v == LINE_DONE) begin
                if (ph == SIZE_LINE_BAD || !got_digit || size_acc > COUNT_MAX - count) begin
                  emit_status(ST_MALFORMED);
                end else if (size_acc == 0) begin
                  begin_line(TRAILER_LINE);
                end else begin
                  left = size_acc;
                  ph   = CHUNK_DATA;
                end
              end
            end
            CHUNK_DATA: begin
              if (!emit_byte(b)) begin
                emit_status(ST_MALFORMED);
              end else begin
                left--;
                if (left == 0) begin
                  ph          = CHUNK_END;
                  crlf_second = 1'b0;
                  saw_cr      = 1'b0;
                end
              end
            end
            CHUNK_END: begin
              // both bytes after the data are judged on the second one
              if (!crlf_second) begin
                saw_cr      = (b == CH_CR);
                crlf_second = 1'b1;
              end else if (!saw_cr || b != CH_LF) begin
                emit_status(ST_MALFORMED);
              end else begin
                crlf_second = 1'b0;
                begin_line(SIZE_LINE);
              end
            end
            TRAILER_LINE: begin
              v = line_step(b);
              if (v == LINE_BAD) begin
                emit_status(ST_MALFORMED);
              end else if (v == LINE_DONE) begin
                if (line_len == 1) emit_status(ST_COMPLETE);
                else begin_line(TRAILER_LINE);
              end
            end
            default: ;
          endcase
        end
      endcase
    endfunction

    function void take_input(logic [1:0] cmd, logic [7:0] b);
      fresh.delete();
      decode_item(cmd, b);
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) pending_results.push_back(fresh[i]);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result item with nothing expected");
        return;
      end
      want = pending_results.pop_front();
      compare("is_status", 32'(want.is_status), 32'(got.is_status));
      compare("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      compare("final_status", 32'(want.final_status), 32'(got.final_status));
      compare("delivered_count", want.delivered_count, got.delivered_count);
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [0:0]  cfg_index_i     = '0;
  logic [31:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] in_byte
  logic [1:0]  s_axis_tuser_i  = '0;   // [1:0] cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;         // [7:0] out_byte, [10:8] final_status,
                                       // [42:11] delivered_count
  logic [0:0]  m_axis_tuser_o;         // [0] is_status
  logic        m_axis_tlast_o;

  deframer_tracker tracker = new();
  stream_item_t    item_plan[$];
  logic [7:0]      text_q[$];
  int              items_sent  = 0;
  bit              src_steady  = 1'b0;
  bit              sink_steady = 1'b0;
  int              sink_hold   = 0;

  http_body_deframer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // mostly no pause, some short ones, a few long
  function automatic int pick_pause(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk_i) begin
    int h;
    h = 0;
    if (sink_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_hold       <= sink_hold - 1;
    end else begin
      h = pick_pause(sink_steady);
      if (h > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_hold       <= h - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.is_status       = m_axis_tuser_o[0];
      got.out_byte        = m_axis_tdata_o[7:0];
      got.final_status    = m_axis_tdata_o[10:8];
      got.delivered_count = m_axis_tdata_o[42:11];
      got.last            = m_axis_tlast_o;
      tracker.check_result(got);
    end
  end

  function automatic void add_item(logic [1:0] cmd, logic [7:0] data);
    stream_item_t it;
    it.cmd  = cmd;
    it.data = data;
    item_plan.push_back(it);
  endfunction

  function automatic void add_noise();
    if ($urandom_range(0, 9) < 7) add_item(CMD_DATA, 8'($urandom_range(0, 255)));
    else add_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_LF) ? 8'h20 : b;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    text_q.push_back(b);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_crlf();
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
  endfunction

  // hex digits with random letter case and optional leading zeros
  function automatic void put_hex(logic [31:0] v, int unsigned lead);
    logic [3:0] nib;
    int         top;
    top = 7;
    while (top > 0 && v[top*4 +: 4] == 4'h0) top--;
    repeat (lead) text_q.push_back("0");
    for (int i = top; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 10) text_q.push_back(8'h30 + 8'(nib));
      else if ($urandom_range(0, 1)) text_q.push_back(8'h41 + 8'(nib) - 8'd10);
      else text_q.push_back(8'h61 + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic void put_size_line(logic [31:0] sz);
    int unsigned start;
    int unsigned target;
    int          r;
    start = text_q.size();
    put_hex(sz, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    r = $urandom_range(0, 39);
    if (r < 8) begin
      put_byte(CH_SEMI);
      repeat ($urandom_range(0, 8)) put_byte(any_but_lf());
    end else if (r == 8) begin
      // pad the extension so the line ends just under, at or over the limit
      target = LINE_LIMIT - 2 + $urandom_range(0, 2);
      put_byte(CH_SEMI);
      while (text_q.size() - start < target - 1) put_byte("x");
    end
    put_crlf();
  endfunction

  function automatic void flush_text();
    foreach (text_q[i]) add_item(CMD_DATA, text_q[i]);
    text_q.delete();
  endfunction

  function automatic void add_chunked();
    int          kind;
    int          pos;
    int unsigned sz;
    logic [7:0]  b1;
    logic [7:0]  b2;
    text_q.delete();
    kind = $urandom_range(0, 23);
    case (kind)
      5: begin
        // a size or trailer line that never ends
        if ($urandom_range(0, 1)) put_str("1;");
        else begin
          put_str("0");
          put_crlf();
        end
        repeat ($urandom_range(LINE_LIMIT, LINE_LIMIT + 4)) put_byte(any_but_lf());
      end
      6: begin
        if ($urandom_range(0, 1)) put_str("3");
        put_byte(CH_LF);
      end
      7: begin
        if ($urandom_range(0, 1)) put_str("100000000");
        else begin
          put_str("1");
          put_crlf();
          put_str("Z");
          put_crlf();
          put_str("ffffffff");
        end
        put_crlf();
      end
      8: begin
        put_str("2");
        put_crlf();
        put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
        b1 = $urandom_range(0, 1) ? CH_CR : 8'($urandom_range(0, 255));
        b2 = $urandom_range(0, 1) ? CH_LF : 8'($urandom_range(0, 255));
        put_byte(b1);
        put_byte(b2);
      end
      9: begin
        case ($urandom_range(0, 4))
          0: ;
          1: put_str(";x");
          2: begin
            put_str("5");
            put_byte(CH_CR);
            put_str("5");
          end
          3: put_str("g");
          default: put_byte(CH_CR);
        endcase
        put_crlf();
      end
      default: begin
        repeat ($urandom_range(0, 3)) begin
          sz = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
          put_size_line(sz);
          repeat (sz) put_byte(8'($urandom_range(0, 255)));
          put_crlf();
        end
        put_size_line(0);
        repeat ($urandom_range(0, 2)) begin
          put_str("Ck: ");
          repeat ($urandom_range(0, 6)) put_byte(any_but_lf());
          put_crlf();
        end
        put_crlf();
        if (kind <= 2) begin
          pos = $urandom_range(0, text_q.size() - 1);
          text_q[pos] = 8'($urandom_range(0, 255));
        end else if (kind <= 4) begin
          pos = $urandom_range(0, text_q.size() - 1);
          while (text_q.size() > pos) void'(text_q.pop_back());
        end
      end
    endcase
    flush_text();
    if (kind == 3 || kind == 4) add_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
    // broken bodies leave the parser anywhere; sometimes pull it back to idle
    if (kind < 10 && $urandom_range(0, 1)) add_item(CMD_CANCEL, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_body(logic [1:0] mode, logic [31:0] len);
    int unsigned n;
    case (mode)
      MODE_CHUNKED: add_chunked();
      MODE_LENGTH: begin
        if (len == 0) begin
          add_noise();
        end else begin
          n = (len > 64) ? $urandom_range(1, 40) : len;
          if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
          repeat (n) add_item(CMD_DATA, 8'($urandom_range(0, 255)));
          if (n != len) add_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        end
      end
      MODE_CLOSE: begin
        repeat ($urandom_range(0, 24)) add_item(CMD_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) != 0) add_item(CMD_CONN_END, 8'($urandom_range(0, 255)));
        else add_item(2'($urandom_range(2, 3)), 8'($urandom_range(0, 255)));
      end
      default: add_noise();
    endcase
  endfunction

  task automatic send_item(stream_item_t it);
    int gap;
    gap = pick_pause(src_steady);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.cmd;
    s_axis_tdata_i  <= it.data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracker.take_input(it.cmd, it.data);
    items_sent++;
  endtask

  task automatic run_plan();
    foreach (item_plan[i]) send_item(item_plan[i]);
    s_axis_tvalid_i <= 1'b0;
    item_plan.delete();
  endtask

  // wait for every owed result, then for items that produce none
  task automatic settle();
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [1:0] mode, logic [31:0] len);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FRAMING_MODE;
    cfg_wdata_i <= 32'(mode);
    @(posedge clk_i);
    tracker.write_reg(CFG_FRAMING_MODE, 32'(mode));
    cfg_index_i <= CFG_BODY_LENGTH;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    tracker.write_reg(CFG_BODY_LENGTH, len);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase();
    logic [1:0]  mode;
    logic [31:0] len;
    int          r;
    int          quota;
    r = $urandom_range(0, 99);
    if (r < 50) mode = MODE_CHUNKED;
    else if (r < 72) mode = MODE_LENGTH;
    else if (r < 94) mode = MODE_CLOSE;
    else mode = MODE_RESERVED;
    r = $urandom_range(0, 99);
    if (r < 10) len = '0;
    else if (r < 80) len = $urandom_range(1, 24);
    else if (r < 92) len = $urandom_range(25, 200);
    else if (r < 96) len = 32'hFFFF_FFFF;
    else len = $urandom;
    set_config(mode, len);
    src_steady  = ($urandom_range(0, 4) == 0);
    sink_steady = ($urandom_range(0, 4) == 0);
    quota = $urandom_range(30, 90);
    while (item_plan.size() < quota) add_body(mode, len);
    run_plan();
    if (!tracker.at_body_start()) begin
      add_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
      @(posedge clk_i);
      run_plan();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero content length from reset: first item completes, cancel at idle
    add_item(CMD_DATA, 8'hFF);
    add_item(CMD_CANCEL, 8'h00);
    run_plan();

    // reserved framing mode
    set_config(MODE_RESERVED, 32'd0);
    add_item(CMD_DATA, 8'h00);
    add_item(CMD_CANCEL, 8'hFF);
    run_plan();

    set_config(MODE_CLOSE, 32'hFFFF_FFFF);
    add_item(CMD_DATA, 8'h00);
    add_item(CMD_DATA, 8'hFF);
    add_item(CMD_CONN_END, 8'h5A);
    run_plan();

    // maximum length cut short by a read failure, then by connection end
    set_config(MODE_LENGTH, 32'hFFFF_FFFF);
    add_item(CMD_DATA, 8'hA5);
    add_item(CMD_READ_FAIL, 8'h00);
    add_item(CMD_DATA, 8'h5A);
    add_item(CMD_CONN_END, 8'h00);
    run_plan();

    set_config(MODE_LENGTH, 32'd1);
    add_item(CMD_DATA, 8'h3C);
    run_plan();

    set_config(MODE_CHUNKED, 32'd0);
    put_str("1");
    put_crlf();
    put_str("Z");
    put_crlf();
    put_str("0");
    put_crlf();
    put_crlf();
    flush_text();
    run_plan();

    while (items_sent < ITEM_TARGET) random_phase();

    settle();
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/hbd_pkg.sv
sv/hbd_core.sv
sv/hbd_outbuf.sv
sv/http_body_deframer_top.sv
bench/testbench.sv
